[sv/daily_byte_quota_tracker_unit_defines.svh]
// Assertion macros shared by the daily byte quota tracker RTL.
`ifndef DAILY_BYTE_QUOTA_TRACKER_UNIT_DEFINES_SVH
`define DAILY_BYTE_QUOTA_TRACKER_UNIT_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define DBQT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define DBQT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/dbqt_pkg.sv]
// Types and constants of the daily byte quota tracker.
package dbqt_pkg;

   localparam int QUOTA_BITS     = 31;
   localparam int SIZE_BITS      = 32;
   localparam int DAY_BITS       = 16;
   localparam int CMD_BITS       = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int REMAIN_BITS    = 32;
   // floor(quota / 10) fits in 28 bits for a 31-bit quota
   localparam int GRACE_BITS     = 28;
   localparam int RECIP_BITS     = 32;
   localparam int PROD_BITS      = QUOTA_BITS + RECIP_BITS;
   // x / 10 == (x * 0xCCCCCCCD) >> 35 for any x below 2^32
   localparam logic [RECIP_BITS-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT = 35;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_QUERY    = 2'd0,
      CMD_ADD_BOTH = 2'd1,
      CMD_ADD_IO   = 2'd2,
      CMD_TIGHTEN  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IO_QUOTA     = 2'd0,
      CSR_ZIP_QUOTA    = 2'd1,
      CSR_TIGHTEN_UNIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      cmd_type               command;
      logic [SIZE_BITS-1:0]  size_bytes;
      logic [DAY_BITS-1:0]   day_number;
   } req_item_type;

   typedef struct packed {
      logic [REMAIN_BITS-1:0] remaining_bytes;
      logic                   zip_over;
      logic                   io_over;
      logic                   day_rolled;
   } rsp_item_type;

   typedef struct packed {
      logic [QUOTA_BITS-1:0] io_quota;
      logic [QUOTA_BITS-1:0] zip_quota;
      logic [QUOTA_BITS-1:0] tighten_unit;
      logic [GRACE_BITS-1:0] zip_grace;
   } cfg_type;

endpackage

[sv/dbqt_ifs.sv]
// Request and response channel interfaces of the daily byte quota tracker.
interface dbqt_req_if;
   logic                                valid;
   logic                                ready;
   dbqt_pkg::cmd_type                   command;
   logic [dbqt_pkg::SIZE_BITS-1:0]      size_bytes;
   logic [dbqt_pkg::DAY_BITS-1:0]       day_number;

   modport source (output valid, command, size_bytes, day_number, input ready);
   modport sink   (input valid, command, size_bytes, day_number, output ready);
endinterface

interface dbqt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [dbqt_pkg::REMAIN_BITS-1:0]    remaining_bytes;
   logic                                zip_over;
   logic                                io_over;
   logic                                day_rolled;

   modport source (output valid, remaining_bytes, zip_over, io_over, day_rolled, input ready);
   modport sink   (input valid, remaining_bytes, zip_over, io_over, day_rolled, output ready);
endinterface

[sv/dbqt_csr.sv]
// Configuration registers and the precomputed ten percent grace.
module dbqt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [dbqt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dbqt_pkg::QUOTA_BITS-1:0]      csr_wdata,
   output dbqt_pkg::cfg_type                    cfg
);

   dbqt_pkg::cfg_type                 cfg_ff;
   dbqt_pkg::cfg_type                 cfg_in;
   logic [dbqt_pkg::PROD_BITS-1:0]    grace_prod;

   // Divide the written value by ten through its reciprocal
   assign grace_prod = dbqt_pkg::PROD_BITS'(csr_wdata)
                       * dbqt_pkg::PROD_BITS'(dbqt_pkg::DIV10_RECIP);

   // Decode the register index; an unknown index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (dbqt_pkg::csr_index_type'(csr_index))
            dbqt_pkg::CSR_IO_QUOTA: begin
               cfg_in.io_quota = csr_wdata;
            end
            dbqt_pkg::CSR_ZIP_QUOTA: begin
               cfg_in.zip_quota = csr_wdata;
               cfg_in.zip_grace = grace_prod[dbqt_pkg::DIV10_SHIFT +: dbqt_pkg::GRACE_BITS];
            end
            dbqt_pkg::CSR_TIGHTEN_UNIT: begin
               cfg_in.tighten_unit = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/dbqt_engine.sv]
// Usage counters, day tracking and the single-pass answer for one request.
`include "daily_byte_quota_tracker_unit_defines.svh"

module dbqt_engine #(
   parameter int CounterBits = 40
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  dbqt_pkg::req_item_type  item,
   input  dbqt_pkg::cfg_type       cfg,
   output dbqt_pkg::rsp_item_type  result
);

   logic [CounterBits-1:0]          used_io_ff, used_io_in;
   logic [CounterBits-1:0]          used_zip_ff, used_zip_in;
   logic [CounterBits-1:0]          tighten_ff, tighten_in;
   logic [dbqt_pkg::DAY_BITS-1:0]   stored_day_ff, stored_day_in;
   logic                            day_known_ff, day_known_in;

   logic                            io_en, zip_en, is_query, roll;
   logic [CounterBits-1:0]          used_io_eff, used_zip_eff, tighten_eff;
   logic [CounterBits-1:0]          zip_quota_ext, io_quota_ext;
   logic [CounterBits:0]            zip_load;
   logic                            zip_under;
   logic [dbqt_pkg::QUOTA_BITS-1:0] zip_left;
   logic [CounterBits:0]            io_sum, zip_sum, tight_sum;
   logic [CounterBits-1:0]          io_sat, zip_sat, tight_sat;

   // Decode the request against the quotas and the stored day
   assign io_en    = cfg.io_quota != '0;
   assign zip_en   = cfg.zip_quota != '0;
   assign is_query = item.command == dbqt_pkg::CMD_QUERY;
   assign roll     = is_query && (io_en || zip_en)
                     && (!day_known_ff || item.day_number != stored_day_ff);

   // A new day answers from cleared counters
   assign used_io_eff  = roll ? '0 : used_io_ff;
   assign used_zip_eff = roll ? '0 : used_zip_ff;
   assign tighten_eff  = roll ? '0 : tighten_ff;

   // Compare the usage with the budgets
   assign zip_quota_ext = CounterBits'(cfg.zip_quota);
   assign io_quota_ext  = CounterBits'(cfg.io_quota);
   assign zip_load      = {1'b0, used_zip_eff} + {1'b0, tighten_eff};
   assign zip_under     = used_zip_eff < zip_quota_ext;
   assign zip_left      = cfg.zip_quota - used_zip_eff[dbqt_pkg::QUOTA_BITS-1:0];

   always_comb begin
      result = '0;
      if (is_query) begin
         result.remaining_bytes = (zip_en && zip_under)
            ? dbqt_pkg::REMAIN_BITS'(zip_left) + dbqt_pkg::REMAIN_BITS'(cfg.zip_grace)
            : '0;
         result.zip_over   = !zip_en || (zip_load > {1'b0, zip_quota_ext});
         result.io_over    = !io_en || (used_io_eff > io_quota_ext);
         result.day_rolled = roll;
      end
   end

   // Saturating adds for the counters
   assign io_sum    = {1'b0, used_io_ff} + (CounterBits + 1)'(item.size_bytes);
   assign zip_sum   = {1'b0, used_zip_ff} + (CounterBits + 1)'(item.size_bytes);
   assign tight_sum = {1'b0, tighten_ff} + (CounterBits + 1)'(cfg.tighten_unit);
   assign io_sat    = io_sum[CounterBits] ? '1 : io_sum[CounterBits-1:0];
   assign zip_sat   = zip_sum[CounterBits] ? '1 : zip_sum[CounterBits-1:0];
   assign tight_sat = tight_sum[CounterBits] ? '1 : tight_sum[CounterBits-1:0];

   // Advance the state for the request that leaves the input register
   always_comb begin
      used_io_in    = used_io_ff;
      used_zip_in   = used_zip_ff;
      tighten_in    = tighten_ff;
      stored_day_in = stored_day_ff;
      day_known_in  = day_known_ff;
      if (go) begin
         case (item.command)
            dbqt_pkg::CMD_QUERY: begin
               if (roll) begin
                  used_io_in    = '0;
                  used_zip_in   = '0;
                  tighten_in    = '0;
                  stored_day_in = item.day_number;
                  day_known_in  = 1'b1;
               end
            end
            dbqt_pkg::CMD_ADD_BOTH: begin
               if (io_en) used_io_in = io_sat;
               if (zip_en) used_zip_in = zip_sat;
            end
            dbqt_pkg::CMD_ADD_IO: begin
               if (io_en) used_io_in = io_sat;
            end
            default: begin
               if (zip_en) tighten_in = tight_sat;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_io_ff    <= '0;
         used_zip_ff   <= '0;
         tighten_ff    <= '0;
         stored_day_ff <= '0;
         day_known_ff  <= 1'b0;
      end else begin
         used_io_ff    <= used_io_in;
         used_zip_ff   <= used_zip_in;
         tighten_ff    <= tighten_in;
         stored_day_ff <= stored_day_in;
         day_known_ff  <= day_known_in;
      end
   end

   `DBQT_ASSERT_NEXT(a_day_held_by_updates, clock, reset, go && !is_query, $stable(stored_day_ff), "day changed by a non-query request")
   `DBQT_ASSERT_NEXT(a_roll_clears_counters, clock, reset, go && roll, used_io_ff == '0 && used_zip_ff == '0 && tighten_ff == '0 && day_known_ff, "rollover did not clear the counters")
   `DBQT_ASSERT_NOW(a_roll_only_on_query, clock, reset, roll, is_query && (io_en || zip_en), "rollover outside an enabled query")

endmodule

[sv/daily_byte_quota_tracker_unit.sv]
// Top level of the daily byte quota tracker: handshake stages around the engine.
`include "daily_byte_quota_tracker_unit_defines.svh"

// Every request produces exactly one response. An accepted request is
// held in the input register, where it is evaluated against the usage
// counters. Once the result register is free, the counters are updated
// and its response is loaded into the result register, where it waits
// until it is taken. One request is accepted per cycle as long as
// responses are taken; the input and result registers decouple the two
// channels, so a stalled response only stops intake once both registers
// hold a request. Writing zip_quota also loads the ten percent grace through
// a multiplier on the configuration path, so configuration takes effect at
// the edge it is written. COUNTER_BITS sets the width of the saturating
// counters.
module daily_byte_quota_tracker_unit #(
   parameter int COUNTER_BITS = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   dbqt_req_if.sink                            req_bus,
   dbqt_rsp_if.source                          rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [dbqt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dbqt_pkg::QUOTA_BITS-1:0]     csr_wdata
);

   dbqt_pkg::cfg_type      cfg;
   dbqt_pkg::req_item_type s1_item_ff, s1_item_in;
   logic                   s1_valid_ff, s1_valid_in;
   dbqt_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   dbqt_pkg::rsp_item_type result;
   logic                   advance;
   logic                   go;

   dbqt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dbqt_engine #(
      .CounterBits (COUNTER_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Move the held request on when the result register is free
   assign advance        = !rsp_valid_ff || rsp_bus.ready;
   assign go             = s1_valid_ff && advance;
   assign req_bus.ready  = !s1_valid_ff || advance;

   // Load the input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_bus.ready) begin
         s1_valid_in = req_bus.valid;
         s1_item_in  = '{command:    req_bus.command,
                         size_bytes: req_bus.size_bytes,
                         day_number: req_bus.day_number};
      end
   end

   // Load the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         rsp_item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Drive the response channel
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.remaining_bytes = rsp_item_ff.remaining_bytes;
   assign rsp_bus.zip_over        = rsp_item_ff.zip_over;
   assign rsp_bus.io_over         = rsp_item_ff.io_over;
   assign rsp_bus.day_rolled      = rsp_item_ff.day_rolled;

   `DBQT_ASSERT_NOW(a_intake_stops_when_full, clock, reset, s1_valid_ff && !advance, !req_bus.ready, "request taken while both stages are full")
   `DBQT_ASSERT_NOW(a_roll_needs_quota, clock, reset, rsp_valid_ff && rsp_item_ff.day_rolled, !(rsp_item_ff.zip_over && rsp_item_ff.io_over), "rollover with both quotas disabled")
   `DBQT_ASSERT_NOW(a_roll_zip_over_empty, clock, reset, rsp_valid_ff && rsp_item_ff.day_rolled && rsp_item_ff.zip_over, rsp_item_ff.remaining_bytes == '0, "bytes left on a disabled compressed budget")

endmodule
